### hw/rtl/tt2_pkg.sv
// ----------------------------------------------------------------------------
// tt2_pkg: shared constants, types and helpers for the Type 2 tag emulator
// Holds the tag geometry, command codes, TLV bytes and the port structs
// that pass between the writer, the store and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tt2_pkg;

  // Tag geometry
  localparam int TAG_BLOCKS = 252;
  localparam int STORE_AW   = $clog2(TAG_BLOCKS);
  localparam int PTR_W      = 10;
  localparam int USED_W     = 9;

  // Command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // TLV and capability container bytes
  localparam logic [7:0] TLV_NDEF   = 8'h03;
  localparam logic [7:0] TLV_LONG   = 8'hFF;
  localparam logic [7:0] TLV_TERM   = 8'hFE;
  localparam logic [7:0] CC_MAGIC   = 8'hE1;
  localparam logic [7:0] CC_VERSION = 8'h10;

  // Fixed UID 08 11 22 33 and its check byte
  localparam logic [31:0] UID_WORD = 32'h0811_2233;
  localparam logic [7:0]  UID_BCC  = 8'h08 ^ 8'h11 ^ 8'h22 ^ 8'h33;

  // NDEF area starts at byte 16 (block 4); lengths from 255 use long form
  localparam logic [STORE_AW-1:0] HDR_BLOCK   = STORE_AW'(4);
  localparam logic [9:0]          SHORT_LIMIT = 10'd255;

  // Writer request: header load or single byte put
  typedef struct packed {
    logic             load_hdr;
    logic [31:0]      hdr_word;
    logic [PTR_W-1:0] hdr_ptr;
    logic             put_byte;
    logic [7:0]       wr_data;
  } tt2_wreq_t;

  // Store write port
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [31:0]         data;
  } tt2_mwr_t;

  // Generated blocks 0 to 3
  function automatic logic [31:0] gen_block(input logic [1:0] k,
                                            input logic [USED_W-1:0] used);
    logic [USED_W:0] up;
    logic [31:0]     w;
    up = {1'b0, used} + (USED_W+1)'(1);
    unique case (k)
      2'd0:    w = UID_WORD;
      2'd1:    w = {24'h0, UID_BCC};
      2'd2:    w = {24'h0, UID_BCC};
      default: w = {CC_MAGIC, CC_VERSION, up[8:1], 8'h00};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tt2_store.sv
// ----------------------------------------------------------------------------
// tt2_store: block store for blocks 4 and up
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tt2_store (
  input  wire logic                          clk,
  input  wire tt2_pkg::tt2_mwr_t             mwr,
  input  wire logic                          rd_en,
  input  wire logic [tt2_pkg::STORE_AW-1:0]  rd_addr,
  output logic      [31:0]                   rd_data
);

  logic [31:0] mem_r [tt2_pkg::TAG_BLOCKS];

  always_ff @(posedge clk) begin
    if (mwr.en) begin
      mem_r[mwr.addr] <= mwr.data;
    end
  end

  // Hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tt2_writer.sv
// ----------------------------------------------------------------------------
// tt2_writer: byte writer for the NDEF area
// Keeps the write pointer and the current block word, and writes the whole
// word through to the store on every byte, so no store read is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tt2_writer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tt2_pkg::tt2_wreq_t req,
  output tt2_pkg::tt2_mwr_t       mwr
);

  logic [tt2_pkg::PTR_W-1:0]    ptr_r;
  logic [31:0]                  cur_r;
  logic [31:0]                  base;
  logic [31:0]                  put_word;
  logic [tt2_pkg::STORE_AW-1:0] put_blk;
  logic                         blk_fits;

  assign put_blk  = ptr_r[tt2_pkg::PTR_W-1:2];
  assign blk_fits = {1'b0, put_blk} < (tt2_pkg::STORE_AW+1)'(tt2_pkg::TAG_BLOCKS);

  // A byte at a block's first lane starts the block from zero
  always_comb begin
    base     = (ptr_r[1:0] == 2'd0) ? 32'h0 : cur_r;
    put_word = base;
    unique case (ptr_r[1:0])
      2'd0:    put_word[31:24] = req.wr_data;
      2'd1:    put_word[23:16] = req.wr_data;
      2'd2:    put_word[15:8]  = req.wr_data;
      default: put_word[7:0]   = req.wr_data;
    endcase
  end

  always_comb begin
    mwr = '0;
    priority if (req.load_hdr) begin
      mwr.en   = 1'b1;
      mwr.addr = tt2_pkg::HDR_BLOCK;
      mwr.data = req.hdr_word;
    end else if (req.put_byte) begin
      mwr.en   = blk_fits;
      mwr.addr = put_blk;
      mwr.data = put_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (req.load_hdr) begin
      ptr_r <= req.hdr_ptr;
    end else if (req.put_byte) begin
      ptr_r <= ptr_r + tt2_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.load_hdr) begin
      cur_r <= req.hdr_word;
    end else if (req.put_byte) begin
      cur_r <= put_word;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/type2_tag_memory_emulator.sv
// ----------------------------------------------------------------------------
// type2_tag_memory_emulator: Type 2 tag memory with one NDEF message
// Loads an NDEF message as a TLV into a block store and serves block reads.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   begin load (length), payload byte, or read of four blocks. Result
//   channel (out_valid/out_ready) carries one transaction per result block.
//   Begin load gives one result (accepted flag, zero data); a payload byte
//   gives none; a read gives four blocks, out_last on the fourth.
//   A begin-load result passes the read stage and the output register; a
//   read enters the read state, then each block passes both in turn.
//   A begin load holds in_ready low until its result leaves the read
//   stage; payload bytes are taken back to back, but the last byte of the
//   message is followed by the terminator write, with in_ready low; a read
//   holds it low while the single store read port issues its four blocks
//   (one block per cycle while out_ready is high) and the read stage drains.
//   Reset clears all control state; the store itself is not cleared, and
//   only blocks written by the current load are ever read from it.
//   A stall on the result side holds the output register; the read stage
//   then holds its data and in_ready stays low until all results have moved.
// ----------------------------------------------------------------------------
`default_nettype none

module type2_tag_memory_emulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [9:0]  in_payload_length,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [7:0]  in_block_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_block_data,
  output logic             out_last,
  output logic             out_accepted,
  output logic             out_delivered
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FE   = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  localparam int UW = tt2_pkg::USED_W;

  // Control state
  logic [1:0]    state_r, state_nxt;
  logic [UW-1:0] used_r;
  logic [7:0]    term_r;
  logic [9:0]    remaining_r;
  logic          loading_r;
  logic          delivered_r;

  // Read sequencer
  logic [7:0] rd_base_r;
  logic       rd_zero_r;
  logic [1:0] iss_cnt_r;

  // Read stage between store and output register
  logic        dq_valid_r;
  logic        dq_src_mem_r;
  logic [31:0] dq_word_r;
  logic        dq_last_r;
  logic        dq_acc_r;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic        out_acc_r;
  logic        out_dlv_r;

  // Handshake decode
  logic in_acc, acc_load, acc_byte, acc_read;
  assign in_ready = (state_r == ST_IDLE) && !dq_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign acc_load = in_acc && (in_command == tt2_pkg::CMD_LOAD);
  assign acc_byte = in_acc && (in_command == tt2_pkg::CMD_BYTE);
  assign acc_read = in_acc && (in_command == tt2_pkg::CMD_READ);

  // Fit check: 4 + ceil((header + length + 1) / 4) blocks
  logic        ld_short;
  logic [10:0] ld_sum;
  logic [9:0]  ld_mem;
  logic [9:0]  ld_term;
  logic        ld_ok;
  logic        ld_zero;
  logic [31:0] ld_hdr_word;
  logic [9:0]  ld_hdr_ptr;

  assign ld_short = in_payload_length < tt2_pkg::SHORT_LIMIT;
  assign ld_zero  = in_payload_length == 10'd0;
  assign ld_sum   = {1'b0, in_payload_length} + (ld_short ? 11'd2 : 11'd4) + 11'd4;
  assign ld_mem   = 10'd4 + {1'b0, ld_sum[10:2]};
  assign ld_term  = ld_mem - 10'd1;
  assign ld_ok    = ld_mem <= 10'(tt2_pkg::TAG_BLOCKS);

  // Header word for block 4; a zero length carries the terminator too
  always_comb begin
    if (ld_short) begin
      ld_hdr_word = {tt2_pkg::TLV_NDEF, in_payload_length[7:0],
                     (ld_zero ? tt2_pkg::TLV_TERM : 8'h00), 8'h00};
      ld_hdr_ptr  = ld_zero ? 10'd19 : 10'd18;
    end else begin
      ld_hdr_word = {tt2_pkg::TLV_NDEF, tt2_pkg::TLV_LONG,
                     6'b0, in_payload_length[9:8], in_payload_length[7:0]};
      ld_hdr_ptr  = 10'd20;
    end
  end

  // Writer requests
  tt2_pkg::tt2_wreq_t wreq;
  tt2_pkg::tt2_mwr_t  mwr;

  always_comb begin
    wreq          = '0;
    wreq.load_hdr = acc_load && ld_ok;
    wreq.hdr_word = ld_hdr_word;
    wreq.hdr_ptr  = ld_hdr_ptr;
    wreq.put_byte = (acc_byte && loading_r) || (state_r == ST_FE);
    wreq.wr_data  = (state_r == ST_FE) ? tt2_pkg::TLV_TERM : in_payload_byte;
  end

  tt2_writer u_writer (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (wreq),
    .mwr   (mwr)
  );

  // Read address and block classification
  logic [UW-1:0] rd_k;
  logic          rd_is_zero, rd_is_gen;
  logic          xfer, issue, issue_mem;
  logic [31:0]   store_rdata;
  logic          rd_hit;

  assign rd_k       = {1'b0, rd_base_r} + {7'b0, iss_cnt_r};
  assign rd_is_zero = rd_zero_r || (rd_k >= used_r);
  assign rd_is_gen  = rd_k < UW'(4);
  assign xfer       = dq_valid_r && (!out_valid_r || out_ready);
  assign issue      = (state_r == ST_READ) && (!dq_valid_r || xfer);
  assign issue_mem  = issue && !rd_is_zero && !rd_is_gen;

  // Delivered once a read after a finished load reaches the terminator block
  assign rd_hit = !loading_r && ({1'b0, in_block_number} < used_r) &&
                  (({1'b0, in_block_number} + UW'(3)) >= {1'b0, term_r});

  tt2_store u_store (
    .clk     (clk),
    .mwr     (mwr),
    .rd_en   (issue_mem),
    .rd_addr (rd_k[tt2_pkg::STORE_AW-1:0]),
    .rd_data (store_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_read) begin
          state_nxt = ST_READ;
        end else if (acc_byte && loading_r && (remaining_r == 10'd1)) begin
          state_nxt = ST_FE;
        end
      end
      ST_FE: begin
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (issue && (iss_cnt_r == 2'd3)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      term_r      <= '0;
      remaining_r <= '0;
      loading_r   <= 1'b0;
      delivered_r <= 1'b0;
      iss_cnt_r   <= '0;
      rd_zero_r   <= 1'b0;
      dq_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Begin load: rejected loads leave everything as it is
      if (acc_load && ld_ok) begin
        used_r      <= ld_mem[UW-1:0];
        term_r      <= ld_term[7:0];
        remaining_r <= in_payload_length;
        loading_r   <= !ld_zero;
        delivered_r <= 1'b0;
      end

      // Payload byte: count down, the terminator write ends the load
      if (acc_byte && loading_r) begin
        remaining_r <= remaining_r - 10'd1;
      end
      if (state_r == ST_FE) begin
        loading_r <= 1'b0;
      end

      // Read: latch the first block and the zero-serve decision, then
      // advance the issue count
      if (acc_read) begin
        rd_base_r <= in_block_number;
        rd_zero_r <= loading_r;
        iss_cnt_r <= '0;
        if (rd_hit) begin
          delivered_r <= 1'b1;
        end
      end else if (issue) begin
        iss_cnt_r <= iss_cnt_r + 2'd1;
      end

      if (acc_load || issue) begin
        dq_valid_r <= 1'b1;
      end else if (xfer) begin
        dq_valid_r <= 1'b0;
      end

      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (acc_load) begin
      dq_src_mem_r <= 1'b0;
      dq_word_r    <= 32'h0;
      dq_last_r    <= 1'b1;
      dq_acc_r     <= ld_ok;
    end else if (issue) begin
      dq_src_mem_r <= issue_mem;
      dq_word_r    <= rd_is_zero ? 32'h0 : tt2_pkg::gen_block(rd_k[1:0], used_r);
      dq_last_r    <= iss_cnt_r == 2'd3;
      dq_acc_r     <= 1'b1;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (xfer) begin
      out_data_r <= dq_src_mem_r ? store_rdata : dq_word_r;
      out_last_r <= dq_last_r;
      out_acc_r  <= dq_acc_r;
      out_dlv_r  <= delivered_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_block_data = out_data_r;
  assign out_last       = out_last_r;
  assign out_accepted   = out_acc_r;
  assign out_delivered  = out_dlv_r;

  // Checks
  a_fe_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FE) |=> (!loading_r && (state_r == ST_IDLE)))
    else $error("terminator write did not end the load");

  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!dq_valid_r && (state_r == ST_IDLE)))
    else $error("input taken while read stage busy");

  a_used_fits: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(tt2_pkg::TAG_BLOCKS))
    else $error("used block count beyond tag size");

  a_store_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_mem |-> ((rd_k >= UW'(4)) && (rd_k < used_r) && !rd_zero_r))
    else $error("store read outside the loaded area");

endmodule

`default_nettype wire
